### rtl/hsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsd_pkg: shared types, tables and helpers of the Hamming decoder
// Beat types, code tables and the selection of the effective width code.
// ----------------------------------------------------------------------------
package hsd_pkg;

    localparam int CW_BITS             = 71;
    localparam int DATA_BITS           = 64;
    localparam int SYN_BITS            = 7;
    localparam int CODE_BITS           = 3;
    localparam int NUM_CODES           = 7;
    localparam int MAX_CHECK_BITS_DEF  = 7;

    localparam logic [CODE_BITS-1:0] CODE_MAX = CODE_BITS'(NUM_CODES - 1);

    localparam logic [6:0] DATA_WIDTH_TAB [NUM_CODES] = '{
        7'd8, 7'd12, 7'd16, 7'd24, 7'd32, 7'd48, 7'd64
    };
    localparam logic [6:0] CODE_LEN_TAB [NUM_CODES] = '{
        7'd12, 7'd17, 7'd21, 7'd29, 7'd38, 7'd54, 7'd71
    };
    localparam logic [6:0] CHECK_IDX_TAB [SYN_BITS] = '{
        7'd0, 7'd1, 7'd3, 7'd7, 7'd15, 7'd31, 7'd63
    };

    typedef struct packed {
        logic [6:0]  codeword_high;
        logic [63:0] codeword_low;
    } cw_beat_t;

    typedef struct packed {
        logic [63:0] data_out;
        logic [6:0]  syndrome;
        logic        corrected;
        logic        out_of_range;
    } res_beat_t;

    // Saturates an unused code and lowers it until its check bits fit.
    function automatic logic [CODE_BITS-1:0] effective_code(
        input logic [CODE_BITS-1:0] width_code,
        input int                   max_checks
    );
        logic [CODE_BITS-1:0] c;
        c = (width_code > CODE_MAX) ? CODE_MAX : width_code;
        for (int s = 0; s < NUM_CODES; s++) begin
            if (c != '0 && (int'(CODE_LEN_TAB[c]) - int'(DATA_WIDTH_TAB[c])) > max_checks)
            begin
                c = c - CODE_BITS'(1);
            end
        end
        return c;
    endfunction

endpackage

### rtl/hamming_sec_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hamming_sec_decoder: single-error-correcting Hamming decoder
// Decodes one codeword of up to 71 bits per cycle while the result is not stalled, at a configured data width.
//
//   Channel   Signals                              Direction
//   cw        cw_valid, cw_stall, cw_beat          codewords in
//   res       res_valid, res_stall, res_beat       decoded beats out
//   cfg       cfg_write_en, cfg_write_data         width code write
//
// A beat is accepted whenever cw_stall is low and passes through
// one input register, the decode logic, and one result register.
// Reset clears the valid flags and sets the width code to zero.
// When the result is stalled both stages hold, so cw_stall follows res_stall
// while a result is waiting.
// ----------------------------------------------------------------------------
module hamming_sec_decoder #(
    parameter int MAX_CHECK_BITS = hsd_pkg::MAX_CHECK_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cw_valid,
    output logic                          cw_stall,
    input  hsd_pkg::cw_beat_t             cw_beat,
    output logic                          res_valid,
    input  logic                          res_stall,
    output hsd_pkg::res_beat_t            res_beat,
    input  logic                          cfg_write_en,
    input  logic [hsd_pkg::CODE_BITS-1:0] cfg_write_data
);
    import hsd_pkg::*;

    logic [CODE_BITS-1:0] width_code_reg;
    logic [CODE_BITS-1:0] width_code_next;
    logic                 in_valid_reg;
    logic                 in_valid_next;
    cw_beat_t             in_beat_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    res_beat_t            out_beat_reg;
    res_beat_t            out_beat_next;
    logic [CODE_BITS-1:0] code;
    logic                 advance;

    assign advance  = !(out_valid_reg && res_stall);
    assign cw_stall = !advance;

    assign width_code_next = cfg_write_en ? cfg_write_data : width_code_reg;
    assign in_valid_next   = advance ? cw_valid : in_valid_reg;
    assign out_valid_next  = advance ? in_valid_reg : out_valid_reg;
    assign code            = effective_code(width_code_reg, MAX_CHECK_BITS);

    hsd_decode u_decode (
        .cw_beat  (in_beat_reg),
        .code     (code),
        .res_beat (out_beat_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            width_code_reg <= '0;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            width_code_reg <= width_code_next;
            in_valid_reg   <= in_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            in_beat_reg  <= cw_beat;
            out_beat_reg <= out_beat_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_beat  = out_beat_reg;

endmodule

### rtl/hsd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsd_decode: combinational single-error-correcting decode
// Masks the codeword to its length, forms the syndrome, flips the addressed bit
// when it lies within the length, strips the check bits and masks the data to its width.
// ----------------------------------------------------------------------------
module hsd_decode (
    input  hsd_pkg::cw_beat_t             cw_beat,
    input  logic [hsd_pkg::CODE_BITS-1:0] code,
    output hsd_pkg::res_beat_t            res_beat
);
    import hsd_pkg::*;

    logic [CW_BITS-1:0]   cw;
    logic [CW_BITS-1:0]   masked;
    logic [CW_BITS-1:0]   fixed;
    logic [SYN_BITS-1:0]  syn;
    logic [DATA_BITS-1:0] data_raw;
    logic [6:0]           len;
    logic [6:0]           width;
    logic                 oor;
    logic                 fix;

    assign cw    = {cw_beat.codeword_high, cw_beat.codeword_low};
    assign len   = CODE_LEN_TAB[code];
    assign width = DATA_WIDTH_TAB[code];

    always_comb
    begin
        for (int i = 0; i < CW_BITS; i++) begin
            masked[i] = cw[i] & (7'(i) < len);
        end
    end

    always_comb
    begin
        syn = '0;
        for (int q = 0; q < SYN_BITS; q++) begin
            for (int i = 0; i < CW_BITS; i++) begin
                if ((((i + 1) >> q) & 1) == 1) begin
                    syn[q] = syn[q] ^ masked[i];
                end
            end
        end
    end

    assign oor = (syn > len);
    assign fix = (syn != '0) && !oor;

    always_comb
    begin
        for (int i = 0; i < CW_BITS; i++) begin
            fixed[i] = masked[i] ^ (fix && (syn == 7'(i + 1)));
        end
    end

    // Data bits sit at every position that is not a power of two.
    always_comb
    begin
        int t;
        t = 0;
        data_raw = '0;
        for (int i = 0; i < CW_BITS; i++) begin
            if (((i + 1) & i) != 0) begin
                data_raw[t] = fixed[i];
                t = t + 1;
            end
        end
    end

    always_comb
    begin
        for (int t = 0; t < DATA_BITS; t++) begin
            res_beat.data_out[t] = data_raw[t] & (7'(t) < width);
        end
        res_beat.syndrome     = syn;
        res_beat.corrected    = fix;
        res_beat.out_of_range = oor;
    end

endmodule
